[sv/u8v_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types, codes and the lead byte decode for the UTF-8 string validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REQUIRE_TERMINATOR = 1'b0,
        CFG_REJECT_EMPTY       = 1'b1
    } t_cfg_addr;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID    = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic require_terminator;
        logic reject_empty;
    } t_cfg;

    typedef struct packed {
        logic       ok;
        logic [1:0] win;
    } t_lead;

    // continuation bytes owed by a lead byte
    function automatic t_lead lead_window(input logic [BYTE_W-1:0] b);
        t_lead r;
        r.ok  = 1'b1;
        r.win = 2'd0;
        if (b inside {[8'h00:8'h7f]}) begin
            r.win = 2'd0;
        end else if (b inside {[8'hc0:8'hdf]}) begin
            r.win = 2'd1;
        end else if (b inside {[8'he0:8'hef]}) begin
            r.win = 2'd2;
        end else if (b inside {[8'hf0:8'hf4]}) begin
            r.win = 2'd3;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return b inside {[8'h80:8'hbf]};
    endfunction

endpackage

[sv/u8v_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_scan
// Per-string scan state: window counter, error tracking and final status.
// ----------------------------------------------------------------------------
module u8v_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [u8v_pkg::BYTE_W-1:0]   i_byte,
    input  logic                         i_last,
    input  u8v_pkg::t_cfg                i_cfg,
    output u8v_pkg::t_status             o_status
);

    logic [1:0]       r_win;
    logic             r_bad;
    u8v_pkg::t_status r_ferr;
    logic             r_first;

    logic [1:0]       n_win;
    logic             n_bad;
    u8v_pkg::t_status n_ferr;
    logic             n_first;

    u8v_pkg::t_lead   w_lead;
    logic [1:0]       w_win_dec;
    logic             w_bad_acc;
    u8v_pkg::t_status w_ferr_upd;

    assign w_lead    = u8v_pkg::lead_window(i_byte);
    assign w_win_dec = r_win - 2'd1;
    assign w_bad_acc = r_bad | ~u8v_pkg::is_cont(i_byte);

    always_comb begin
        n_win      = r_win;
        n_bad      = r_bad;
        w_ferr_upd = r_ferr;
        if (r_ferr == u8v_pkg::ST_VALID) begin
            if (r_win != 2'd0) begin
                n_win = w_win_dec;
                n_bad = w_bad_acc;
                if (w_win_dec == 2'd0) begin
                    if (w_bad_acc) begin
                        w_ferr_upd = u8v_pkg::ST_INVALID;
                    end
                    n_bad = 1'b0;
                end else if (i_last) begin
                    w_ferr_upd = u8v_pkg::ST_OVERFLOW;
                end
            end else if (i_byte == '0 && !i_last) begin
                w_ferr_upd = u8v_pkg::ST_INVALID;
            end else if (!w_lead.ok) begin
                w_ferr_upd = u8v_pkg::ST_INVALID;
            end else if (w_lead.win != 2'd0) begin
                if (i_last) begin
                    w_ferr_upd = u8v_pkg::ST_OVERFLOW;
                end else begin
                    n_win = w_lead.win;
                    n_bad = 1'b0;
                end
            end
        end
        n_ferr  = w_ferr_upd;
        n_first = i_last;
        if (i_last) begin
            n_win  = 2'd0;
            n_bad  = 1'b0;
            n_ferr = u8v_pkg::ST_VALID;
        end
    end

    always_comb begin
        if (i_cfg.require_terminator && i_byte != '0) begin
            o_status = u8v_pkg::ST_INVALID;
        end else begin
            o_status = w_ferr_upd;
        end
        if (o_status == u8v_pkg::ST_VALID && i_cfg.reject_empty && r_first
            && i_byte == '0) begin
            o_status = u8v_pkg::ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= 2'd0;
            r_bad   <= 1'b0;
            r_ferr  <= u8v_pkg::ST_VALID;
            r_first <= 1'b1;
        end else if (i_step) begin
            r_win   <= n_win;
            r_bad   <= n_bad;
            r_ferr  <= n_ferr;
            r_first <= n_first;
        end
    end

endmodule

[sv/utf8_string_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_string_validator
// Checks a byte stream for well-formed UTF-8 strings, one status per string.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one string byte per beat in tdata, tlast on its final byte.
//   Master channel: one beat per string carrying the status (0 valid,
//   1 invalid format, 2 sequence runs past the string end).
//   Throughput is one byte per cycle while no final byte waits for the
//   status register; the scan state update is the per-byte work, done
//   between the input register and the status register. A final byte is
//   held in the input register, and its status goes to the status register.
//   When the master side stalls, bytes that are not final keep flowing in;
//   a final byte waits in the input register until the status register
//   frees up, and the slave side is held off only while it waits.
//   Configuration writes are taken at any edge with i_cfg_we high and should
//   be issued while no string is in flight. Reset sets require_terminator to
//   1, reject_empty to 0, and clears all per-string state.
// ----------------------------------------------------------------------------
module utf8_string_validator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [u8v_pkg::BYTE_W-1:0]       i_s_axis_tdata,  // [7:0] byte_value
    input  logic                             i_s_axis_tlast,  // last_byte
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [u8v_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,  // [1:0] status, [7:2] zero
    input  logic                             i_cfg_we,
    input  logic [u8v_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [u8v_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    u8v_pkg::t_cfg                 r_cfg;
    logic                          r_in_valid;
    logic [u8v_pkg::BYTE_W-1:0]    r_in_byte;
    logic                          r_in_last;
    logic                          r_out_valid;
    u8v_pkg::t_status              r_out_status;

    logic                          w_out_free;
    logic                          w_adv;
    logic                          w_in_acc;
    u8v_pkg::t_status              w_status;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_adv           = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.require_terminator <= 1'b1;
            r_cfg.reject_empty       <= 1'b0;
        end else if (i_cfg_we) begin
            case (u8v_pkg::t_cfg_addr'(i_cfg_addr))
                u8v_pkg::CFG_REQUIRE_TERMINATOR: r_cfg.require_terminator <= i_cfg_data[0];
                u8v_pkg::CFG_REJECT_EMPTY:       r_cfg.reject_empty       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    u8v_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_status <= w_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(u8v_pkg::OUT_DATA_W - u8v_pkg::STATUS_W){1'b0}}, r_out_status};

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3)
        else $error("status code out of range");

    a_mid_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> o_s_axis_tready)
        else $error("non-final byte stalled the input");

    a_final_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> o_m_axis_tvalid)
        else $error("final byte produced no status beat");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 string validator. Strings are fed one
// byte per beat from a queue. A local decoder tracks the character windows
// and predicts one status per string. Each status beat is compared with the
// oldest prediction. Both sides stall at random, and both config bits are
// swept between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [u8v_pkg::BYTE_W-1:0] value;
        logic                       last;
    } t_byte_beat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [u8v_pkg::BYTE_W-1:0]     s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [u8v_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_we = 1'b0;
    logic [u8v_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [u8v_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    t_byte_beat                 byte_beats_q[$];
    logic [u8v_pkg::BYTE_W-1:0] str_buf[$];
    u8v_pkg::t_status           pending_status_q[$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  rx_hold_left = 0;
    bit  tx_pause = 1'b0;
    bit  byte_taken = 1'b0;
    int  fail_cnt = 0;
    int  bytes_queued = 0;

    // predictor copy of the per-string state and the config
    u8v_pkg::t_status string_err = u8v_pkg::ST_VALID;
    logic [1:0]       cont_owed = 2'd0;
    logic             cont_bad = 1'b0;
    logic             first_of_string = 1'b1;
    logic             req_term = 1'b1;
    logic             rej_empty = 1'b0;

    utf8_string_validator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] byte_value
        .i_s_axis_tlast  (s_tlast),   // last_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [1:0] status, [7:2] zero
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int lead_span(input logic [u8v_pkg::BYTE_W-1:0] b);
        if (b <= 8'h7f) return 0;
        if (b >= 8'hc0 && b <= 8'hdf) return 1;
        if (b >= 8'he0 && b <= 8'hef) return 2;
        if (b >= 8'hf0 && b <= 8'hf4) return 3;
        return -1;
    endfunction

    function automatic void track_utf8_byte(input logic [u8v_pkg::BYTE_W-1:0] b,
                                            input logic last);
        int               span;
        u8v_pkg::t_status st;
        if (string_err == u8v_pkg::ST_VALID) begin
            if (cont_owed != 2'd0) begin
                if (b < 8'h80 || b > 8'hbf) cont_bad = 1'b1;
                cont_owed = cont_owed - 2'd1;
                if (cont_owed == 2'd0) begin
                    if (cont_bad) string_err = u8v_pkg::ST_INVALID;
                    cont_bad = 1'b0;
                end else if (last) begin
                    string_err = u8v_pkg::ST_OVERFLOW;
                end
            end else if (b == 8'h00 && !last) begin
                string_err = u8v_pkg::ST_INVALID;
            end else begin
                span = lead_span(b);
                if (span < 0) begin
                    string_err = u8v_pkg::ST_INVALID;
                end else if (span > 0) begin
                    if (last) begin
                        string_err = u8v_pkg::ST_OVERFLOW;
                    end else begin
                        cont_owed = span[1:0];
                        cont_bad  = 1'b0;
                    end
                end
            end
        end
        if (!last) begin
            first_of_string = 1'b0;
        end else begin
            st = (req_term && b != 8'h00) ? u8v_pkg::ST_INVALID : string_err;
            if (st == u8v_pkg::ST_VALID && rej_empty && first_of_string && b == 8'h00)
                st = u8v_pkg::ST_INVALID;
            pending_status_q.push_back(st);
            string_err      = u8v_pkg::ST_VALID;
            cont_owed       = 2'd0;
            cont_bad        = 1'b0;
            first_of_string = 1'b1;
        end
    endfunction

    // status check first, then the byte prediction of the same edge
    always @(posedge i_clk) begin
        u8v_pkg::t_status exp_st;
        if (m_tvalid && m_tready) begin
            if (pending_status_q.size() == 0) begin
                $error("status beat with nothing expected, actual %0d", m_tdata[1:0]);
                fail_cnt++;
            end else begin
                exp_st = pending_status_q.pop_front();
                if (m_tdata[u8v_pkg::STATUS_W-1:0] !== exp_st) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_st, m_tdata[u8v_pkg::STATUS_W-1:0]);
                    fail_cnt++;
                end
            end
        end
        byte_taken = s_tvalid && s_tready;
        if (byte_taken) track_utf8_byte(s_tdata, s_tlast);
    end

    always @(negedge i_clk) begin
        t_byte_beat nb;
        if (!s_tvalid || byte_taken) begin
            if (tx_pause || byte_beats_q.size() == 0 ||
                $urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                nb = byte_beats_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nb.value;
                s_tlast  <= nb.last;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_str();
        t_byte_beat nb;
        if (str_buf.size() == 0) str_buf.push_back(8'h00);
        foreach (str_buf[i]) begin
            nb.value = str_buf[i];
            nb.last  = (i == str_buf.size() - 1);
            byte_beats_q.push_back(nb);
        end
        bytes_queued += str_buf.size();
        str_buf.delete();
    endtask

    task automatic add_char(input int span);
        case (span)
            0: str_buf.push_back(8'($urandom_range(8'h01, 8'h7f)));
            1: str_buf.push_back(8'($urandom_range(8'hc0, 8'hdf)));
            2: str_buf.push_back(8'($urandom_range(8'he0, 8'hef)));
            default: str_buf.push_back(8'($urandom_range(8'hf0, 8'hf4)));
        endcase
        repeat (span) str_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
    endtask

    task automatic add_random_string();
        int kind;
        int idx;
        kind = $urandom_range(99);
        if (kind < 85) begin
            repeat ($urandom_range(0, 4)) add_char($urandom_range(0, 3));
            if (kind >= 70 && str_buf.size() > 0) begin
                // broken sequence: cut short or corrupt one byte
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(1, 2))
                        if (str_buf.size() > 1) void'(str_buf.pop_back());
                end else begin
                    idx = $urandom_range(str_buf.size() - 1);
                    str_buf[idx] = 8'($urandom_range(255));
                end
            end
        end else begin
            repeat ($urandom_range(1, 6)) str_buf.push_back(8'($urandom_range(255)));
        end
        if (str_buf.size() == 0 || $urandom_range(99) < (req_term ? 85 : 50))
            str_buf.push_back(8'h00);
        send_str();
    endtask

    task automatic send_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at) add_random_string();
    endtask

    task automatic write_cfg(input u8v_pkg::t_cfg_addr addr, input logic val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (addr)
            u8v_pkg::CFG_REQUIRE_TERMINATOR: req_term  = val;
            u8v_pkg::CFG_REJECT_EMPTY:       rej_empty = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (byte_beats_q.size() != 0 || s_tvalid || pending_status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        tx_idle_pct = 12;
        rx_idle_pct = 51;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: terminator required, lone terminator allowed
        str_buf = '{8'h00};                      send_str();
        str_buf = '{8'h41, 8'h00};               send_str();
        str_buf = '{8'h7f, 8'h00};               send_str();
        str_buf = '{8'hc3, 8'ha9, 8'h00};        send_str();
        str_buf = '{8'he2, 8'h82, 8'hac, 8'h00}; send_str();
        str_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h00}; send_str();
        str_buf = '{8'h00, 8'h41, 8'h00};        send_str();
        str_buf = '{8'h80, 8'h00};               send_str();
        str_buf = '{8'hff, 8'h00};               send_str();
        str_buf = '{8'hf5, 8'h00};               send_str();
        str_buf = '{8'hc3, 8'h41, 8'h00};        send_str();
        str_buf = '{8'h41};                      send_str();
        wait_idle();

        write_cfg(u8v_pkg::CFG_REQUIRE_TERMINATOR, 1'b0);
        write_cfg(u8v_pkg::CFG_REJECT_EMPTY, 1'b1);
        str_buf = '{8'h00};                      send_str();
        str_buf = '{8'hc3};                      send_str();
        str_buf = '{8'he2, 8'h82};               send_str();
        str_buf = '{8'hf0, 8'h9f, 8'h41};        send_str();
        str_buf = '{8'hff, 8'h41, 8'hc3};        send_str();
        str_buf = '{8'hf0, 8'h9f, 8'h98, 8'h80}; send_str();
        str_buf = '{8'h41};                      send_str();
        send_random(130);
        wait_idle();

        tx_idle_pct = 51;
        rx_idle_pct = 12;
        write_cfg(u8v_pkg::CFG_REQUIRE_TERMINATOR, 1'b1);
        send_random(130);
        while (byte_beats_q.size() > 60) @(posedge i_clk);
        tx_pause = 1'b1;
        while (pending_status_q.size() != 0) @(posedge i_clk);
        tx_pause = 1'b0;
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_cfg(u8v_pkg::CFG_REQUIRE_TERMINATOR, 1'b0);
        write_cfg(u8v_pkg::CFG_REJECT_EMPTY, 1'b0);
        @(posedge i_clk);
        rx_hold_left = 300;
        send_random(140);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/u8v_pkg.sv
sv/u8v_scan.sv
sv/utf8_string_validator.sv
tb/tb_top.sv
